// ===== hdl/bpc_pkg.sv =====
// Shared types and constants for the barometric compensation block.
package bpc_pkg;

    localparam int BPC_QDEPTH = 2;
    localparam int BPC_REG_W  = 48;
    localparam int BPC_IDX_W  = 3;
    localparam int BPC_NREGS  = 4;
    localparam int BPC_DIV_STEPS = 64;

    localparam logic [BPC_IDX_W-1:0] REG_TEMP    = 3'd0;
    localparam logic [BPC_IDX_W-1:0] REG_PRESS_A = 3'd1;
    localparam logic [BPC_IDX_W-1:0] REG_PRESS_B = 3'd2;
    localparam logic [BPC_IDX_W-1:0] REG_PRESS_C = 3'd3;

    // Decoded calibration words
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_coef;

    // Item handed from the front end to the compute pipeline
    typedef struct packed {
        logic signed [17:0] d1;
        logic signed [16:0] d2;
        logic        [19:0] adc_p;
    } t_fitem;

    // Values that ride alongside the arithmetic through the pipeline
    typedef struct packed {
        logic        [19:0] adc_p;
        logic signed [24:0] tf;
        logic signed [19:0] tc;
        logic               neg;
        logic               zero;
    } t_side;

endpackage

// ===== hdl/bpc_if.sv =====
// Valid/ready channel interfaces for sample items and result items.
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] fine_temperature;
    logic signed [23:0] temperature_centi;
    logic        [31:0] pressure_q24_8;
    logic               pressure_valid;
    modport source (output valid, output fine_temperature, output temperature_centi,
                    output pressure_q24_8, output pressure_valid, input ready);
    modport sink   (input valid, input fine_temperature, input temperature_centi,
                    input pressure_q24_8, input pressure_valid, output ready);
endinterface

// ===== hdl/baro_temp_pressure_compensation.sv =====
// Top level of the barometric temperature and pressure compensation block.
//
// Usage:
//   i_smp carries one item per raw temperature / raw pressure sample pair;
//   o_res returns one item per sample: fine temperature, temperature in
//   0.01 degC, pressure in Pa as unsigned Q24.8 and a pressure-valid flag
//   (low, with pressure zero, when the computed divisor is zero).
//   Calibration is loaded through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no item is in flight; indexes beyond the last register are ignored.
// Throughput: one item per cycle, sustained while results are read; the pipeline holds while a result waits unread.
// Pipeline: a result passes the front register, the queue and the
//   86-stage pipeline, whose first stage loads straight from the queue;
//   most stages are the 64 one-bit steps of the restoring divider and the
//   32x32-based multipliers.
// Reset: clears the calibration registers, the queue and the item valid bits.
// Stall: while a result waits unread the pipeline holds; the front register
//   and the queue keep taking items until the queue fills, then ready drops.
module baro_temp_pressure_compensation
    import bpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = BPC_QDEPTH
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [BPC_IDX_W-1:0] i_cfg_idx,
    input  logic [BPC_REG_W-1:0] i_cfg_data,
    bpc_in_if.sink               i_smp,
    bpc_out_if.source            o_res
);

    logic [BPC_REG_W-1:0] r_cfg [BPC_NREGS];
    t_coef  coef;
    t_fitem f_item;
    t_fitem q_item;
    logic   f_valid;
    logic   q_full;
    logic   q_empty;
    logic   q_push;
    logic   q_pop;

    // Calibration registers; writes to unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BPC_NREGS; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < BPC_IDX_W'(BPC_NREGS))) begin
            r_cfg[i_cfg_idx[$clog2(BPC_NREGS)-1:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        coef.t1 = r_cfg[REG_TEMP[1:0]][15:0];
        coef.t2 = r_cfg[REG_TEMP[1:0]][31:16];
        coef.t3 = r_cfg[REG_TEMP[1:0]][47:32];
        coef.p1 = r_cfg[REG_PRESS_A[1:0]][15:0];
        coef.p2 = r_cfg[REG_PRESS_A[1:0]][31:16];
        coef.p3 = r_cfg[REG_PRESS_A[1:0]][47:32];
        coef.p4 = r_cfg[REG_PRESS_B[1:0]][15:0];
        coef.p5 = r_cfg[REG_PRESS_B[1:0]][31:16];
        coef.p6 = r_cfg[REG_PRESS_B[1:0]][47:32];
        coef.p7 = r_cfg[REG_PRESS_C[1:0]][15:0];
        coef.p8 = r_cfg[REG_PRESS_C[1:0]][31:16];
        coef.p9 = r_cfg[REG_PRESS_C[1:0]][47:32];
    end

    // Hand the front item over whenever the queue has room
    assign q_push = f_valid && !q_full;

    bpc_front u_front (
        .i_clk,
        .i_rst_n,
        .i_coef  (coef),
        .i_smp   (i_smp),
        .o_item  (f_item),
        .o_valid (f_valid),
        .i_taken (q_push)
    );

    bpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk,
        .i_rst_n,
        .i_push  (q_push),
        .i_data  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_item),
        .o_empty (q_empty)
    );

    bpc_back u_back (
        .i_clk,
        .i_rst_n,
        .i_coef       (coef),
        .i_item       (q_item),
        .i_item_valid (!q_empty),
        .o_pop        (q_pop),
        .o_res        (o_res)
    );

endmodule

// ===== hdl/bpc_front.sv =====
// Front end: accept a sample item and form the temperature differences.
module bpc_front
    import bpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_coef      i_coef,
    bpc_in_if.sink     i_smp,
    output t_fitem     o_item,
    output logic       o_valid,
    input  logic       i_taken
);

    logic   r_fv;
    t_fitem r_item;
    t_fitem n_item;
    logic   rdy;

    assign rdy         = !r_fv || i_taken;
    assign i_smp.ready = rdy;

    always_comb begin
        n_item.d1    = $signed({1'b0, i_smp.raw_temperature[19:3]})
                     - $signed({1'b0, i_coef.t1, 1'b0});
        n_item.d2    = $signed({1'b0, i_smp.raw_temperature[19:4]})
                     - $signed({1'b0, i_coef.t1});
        n_item.adc_p = i_smp.raw_pressure;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (rdy) begin
            r_fv <= i_smp.valid;
        end
        if (rdy && i_smp.valid) begin
            r_item <= n_item;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_fv;

endmodule

// ===== hdl/bpc_queue.sv =====
// Short queue between the front end and the compute pipeline.
module bpc_queue
    import bpc_pkg::*;
#(
    parameter int DEPTH = BPC_QDEPTH
)(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_fitem i_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_fitem o_data,
    output logic   o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_fitem          r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= bump(r_wp);
            end
            if (i_pop) begin
                r_rp <= bump(r_rp);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

// ===== hdl/bpc_mul64.sv =====
// Two-stage 64x64 multiplier keeping the low 64 bits, built from 32x32 products.
module bpc_mul64 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] n_ll;
    logic [31:0] n_hl;
    logic [31:0] n_lh;
    logic [63:0] r_ll;
    logic [31:0] r_hl;
    logic [31:0] r_lh;
    logic [63:0] r_p;

    assign n_ll = i_a[31:0] * i_b[31:0];
    assign n_hl = 32'(i_a[63:32] * i_b[31:0]);
    assign n_lh = 32'(i_a[31:0] * i_b[63:32]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= n_ll;
            r_hl <= n_hl;
            r_lh <= n_lh;
            r_p  <= r_ll + {r_hl + r_lh, 32'b0};
        end
    end

    assign o_p = r_p;

endmodule

// ===== hdl/bpc_back.sv =====
// Compute pipeline: temperature, pressure terms, restoring divider, output register.
module bpc_back
    import bpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_coef      i_coef,
    input  t_fitem     i_item,
    input  logic       i_item_valid,
    output logic       o_pop,
    bpc_out_if.source  o_res
);

    localparam int S_DIV0 = 16;
    localparam int S_QUO  = S_DIV0 + BPC_DIV_STEPS;
    localparam int NS     = S_QUO + 6;

    logic        en;
    logic        r_vld  [1:NS];
    t_side       r_side [1:NS];
    t_side       n_side [1:NS];

    logic [63:0] m_a, m_b, m_c, m_d, m_e, m_f, m_g, m_h, m_i, m_j, m_k, m_l, m_m;
    logic [63:0] r_a1 [2];
    logic [63:0] r_pa;
    logic [63:0] r_e  [2];
    logic [63:0] r_f  [2];
    logic [63:0] r_b11, r_a11, r_a12, r_num;
    logic [20:0] r_pp;
    logic [63:0] r_ua;
    logic [30:0] r_ub;
    logic [30:0] r_rem  [BPC_DIV_STEPS];
    logic [63:0] r_work [BPC_DIV_STEPS];
    logic [30:0] r_ubd  [BPC_DIV_STEPS];
    logic [30:0] n_rem  [BPC_DIV_STEPS];
    logic [63:0] n_work [BPC_DIV_STEPS];
    logic [63:0] r_q;
    logic [63:0] r_qd [4];
    logic [63:0] r_l  [2];
    logic [63:0] r_sum;
    logic [31:0] r_pres;
    logic        r_pvld;

    logic signed [27:0] n_w;
    logic signed [27:0] n_t5;
    logic [63:0] n_dv;
    logic [63:0] n_pf;
    logic [63:0] n_s;

    // Advance the whole pipeline unless a finished item waits unread
    assign en    = !r_vld[NS] || o_res.ready;
    assign o_pop = en && i_item_valid;

    bpc_mul64 u_mul_a (.i_clk, .i_en(en), .i_a(64'($signed(i_item.d1))),
                       .i_b(64'($signed(i_coef.t2))), .o_p(m_a));
    bpc_mul64 u_mul_b (.i_clk, .i_en(en), .i_a(64'($signed(i_item.d2))),
                       .i_b(64'($signed(i_item.d2))), .o_p(m_b));
    bpc_mul64 u_mul_c (.i_clk, .i_en(en), .i_a($signed(m_b) >>> 12),
                       .i_b(64'($signed(i_coef.t3))), .o_p(m_c));
    bpc_mul64 u_mul_d (.i_clk, .i_en(en), .i_a(r_pa), .i_b(r_pa), .o_p(m_d));
    bpc_mul64 u_mul_e (.i_clk, .i_en(en), .i_a(r_pa),
                       .i_b(64'($signed(i_coef.p5))), .o_p(m_e));
    bpc_mul64 u_mul_f (.i_clk, .i_en(en), .i_a(r_pa),
                       .i_b(64'($signed(i_coef.p2))), .o_p(m_f));
    bpc_mul64 u_mul_g (.i_clk, .i_en(en), .i_a(m_d),
                       .i_b(64'($signed(i_coef.p6))), .o_p(m_g));
    bpc_mul64 u_mul_h (.i_clk, .i_en(en), .i_a(m_d),
                       .i_b(64'($signed(i_coef.p3))), .o_p(m_h));
    bpc_mul64 u_mul_i (.i_clk, .i_en(en), .i_a(r_a12),
                       .i_b({48'b0, i_coef.p1}), .o_p(m_i));
    bpc_mul64 u_mul_j (.i_clk, .i_en(en), .i_a(r_num), .i_b(64'd3125), .o_p(m_j));
    bpc_mul64 u_mul_k (.i_clk, .i_en(en), .i_a(n_s), .i_b(n_s), .o_p(m_k));
    bpc_mul64 u_mul_l (.i_clk, .i_en(en), .i_a(r_q),
                       .i_b(64'($signed(i_coef.p8))), .o_p(m_l));
    bpc_mul64 u_mul_m (.i_clk, .i_en(en), .i_a(m_k),
                       .i_b(64'($signed(i_coef.p9))), .o_p(m_m));

    always_comb begin
        n_w  = 28'($signed(r_side[5].tf));
        n_t5 = (n_w <<< 2) + n_w + 28'sd128;
        n_dv = $signed(m_i) >>> 33;
        n_s  = $signed(r_q) >>> 13;
        n_pf = ($signed(r_sum) >>> 8) + (64'($signed(i_coef.p7)) << 4);
    end

    // Side values: shift, then overwrite where a stage produces them
    always_comb begin
        for (int k = 2; k <= NS; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[1]       = '0;
        n_side[1].adc_p = i_item.adc_p;
        n_side[5].tf    = 25'($signed(r_a1[1]) + ($signed(m_c) >>> 14));
        n_side[6].tc    = 20'(n_t5 >>> 8);
        n_side[15].neg  = m_j[63] ^ n_dv[63];
        n_side[15].zero = (n_dv == 64'd0);
    end

    // One quotient bit per divider stage
    always_comb begin
        logic [31:0] trial;
        logic [30:0] rem_in;
        logic [63:0] work_in;
        logic [30:0] ub_in;
        logic        ge;
        for (int k = 0; k < BPC_DIV_STEPS; k++) begin
            rem_in  = (k == 0) ? '0   : r_rem[(k == 0) ? 0 : k - 1];
            work_in = (k == 0) ? r_ua : r_work[(k == 0) ? 0 : k - 1];
            ub_in   = (k == 0) ? r_ub : r_ubd[(k == 0) ? 0 : k - 1];
            trial   = {rem_in, work_in[63]};
            ge      = (trial >= {1'b0, ub_in});
            n_rem[k]  = ge ? 31'(trial - {1'b0, ub_in}) : trial[30:0];
            n_work[k] = {work_in[62:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[1] <= i_item_valid;
            for (int k = 2; k <= NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 1; k <= NS; k++) begin
                r_side[k] <= n_side[k];
            end

            r_a1[0] <= $signed(m_a) >>> 11;
            r_a1[1] <= r_a1[0];

            r_pa         <= 64'($signed(r_side[5].tf)) - 64'd128000;

            r_e[0] <= m_e;
            r_e[1] <= r_e[0];
            r_f[0] <= m_f;
            r_f[1] <= r_f[0];

            r_b11 <= m_g + (r_e[1] << 17) + (64'($signed(i_coef.p4)) << 35);
            r_a11 <= ($signed(m_h) >>> 8) + $signed(r_f[1] << 12) + $signed(64'd1 << 47);
            r_pp  <= 21'd1048576 - {1'b0, r_side[10].adc_p};

            r_num <= {12'b0, r_pp, 31'b0} - r_b11;
            r_a12 <= r_a11;

            // Split signs and magnitudes for the divider
            r_ua <= m_j[63] ? (64'd0 - m_j) : m_j;
            r_ub <= n_dv[63] ? 31'(64'd0 - n_dv) : n_dv[30:0];

            for (int k = 0; k < BPC_DIV_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_work[k] <= n_work[k];
                r_ubd[k]  <= (k == 0) ? r_ub : r_ubd[(k == 0) ? 0 : k - 1];
            end

            r_q <= r_side[S_QUO-1].neg ? (64'd0 - r_work[BPC_DIV_STEPS-1])
                                       : r_work[BPC_DIV_STEPS-1];

            r_qd[0] <= r_q;
            for (int k = 1; k < 4; k++) begin
                r_qd[k] <= r_qd[k-1];
            end
            r_l[0] <= m_l;
            r_l[1] <= r_l[0];

            r_sum <= $signed(r_qd[3]) + ($signed(m_m) >>> 25) + ($signed(r_l[1]) >>> 19);

            // Saturate to the unsigned 32-bit range; drop to zero on a zero divisor
            if (r_side[NS-1].zero || n_pf[63]) begin
                r_pres <= '0;
            end else if (|n_pf[62:32]) begin
                r_pres <= '1;
            end else begin
                r_pres <= n_pf[31:0];
            end
            r_pvld <= !r_side[NS-1].zero;
        end
    end

    assign o_res.valid             = r_vld[NS];
    assign o_res.fine_temperature  = 32'($signed(r_side[NS].tf));
    assign o_res.temperature_centi = 24'($signed(r_side[NS].tc));
    assign o_res.pressure_q24_8    = r_pres;
    assign o_res.pressure_valid    = r_pvld;

endmodule

// ===== hdl/bpc_chk.sv =====
// Port-level checker for the compensation block, bound to the top level.
module bpc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_fine,
    input logic [23:0] i_centi,
    input logic [31:0] i_pres,
    input logic        i_pvld
);

    logic signed [39:0] w_t5;
    logic        [23:0] w_centi;

    always_comb begin
        w_t5    = 40'($signed(i_fine)) * 40'sd5 + 40'sd128;
        w_centi = 24'(w_t5 >>> 8);
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_pvld |-> i_pres == 32'd0)
        else $error("pressure not zero on zero divisor");

    a_centi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_centi == w_centi)
        else $error("centi temperature does not match fine temperature");

endmodule

bind baro_temp_pressure_compensation bpc_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_fine      (o_res.fine_temperature),
    .i_centi     (o_res.temperature_centi),
    .i_pres      (o_res.pressure_q24_8),
    .i_pvld      (o_res.pressure_valid)
);

// ===== tb/baro_temp_pressure_compensation_tb.sv =====
// Testbench for the barometric compensation block: predicted results, checked in order.

class bpc_scoreboard;
    typedef struct {
        logic signed [31:0] fine;
        logic signed [23:0] centi;
        logic        [31:0] press;
        logic               pvalid;
    } t_comp;

    logic [47:0] cal [4];
    t_comp       pending [$];
    int          errors;

    function new();
        foreach (cal[i]) cal[i] = '0;
        errors = 0;
    endfunction

    function void write_cal(logic [2:0] idx, logic [47:0] val);
        if (idx < 4) cal[idx] = val;
    endfunction

    // Sign-extend one 16-bit calibration word to 64 bits.
    function logic signed [63:0] sw(logic [47:0] r, int pos);
        logic [15:0] w;
        w = r[pos +: 16];
        return {{48{w[15]}}, w};
    endfunction

    function t_comp compensate(logic [19:0] raw_t, logic [19:0] raw_p);
        logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] at, ap, d, a, b, tf, tc, p, num, mn;
        t_comp r;
        t1 = {48'd0, cal[0][15:0]};
        t2 = sw(cal[0], 16);
        t3 = sw(cal[0], 32);
        p1 = {48'd0, cal[1][15:0]};
        p2 = sw(cal[1], 16);
        p3 = sw(cal[1], 32);
        p4 = sw(cal[2], 0);
        p5 = sw(cal[2], 16);
        p6 = sw(cal[2], 32);
        p7 = sw(cal[3], 0);
        p8 = sw(cal[3], 16);
        p9 = sw(cal[3], 32);
        at = {44'd0, raw_t};
        ap = {44'd0, raw_p};
        mn = {1'b1, 63'd0};
        // temperature path
        d  = (at >>> 3) - (t1 <<< 1);
        a  = (d * t2) >>> 11;
        d  = (at >>> 4) - t1;
        b  = (((d * d) >>> 12) * t3) >>> 14;
        tf = a + b;
        tc = (tf * 64'sd5 + 64'sd128) >>> 8;
        // pressure path, every step wraps at 64 bits
        a = tf - 64'sd128000;
        b = a * a * p6;
        b = b + ((a * p5) <<< 17);
        b = b + (p4 <<< 35);
        a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
        a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
        r.fine  = tf[31:0];
        r.centi = tc[23:0];
        if (a == 0) begin
            r.press  = '0;
            r.pvalid = 1'b0;
        end else begin
            p   = 64'sd1048576 - ap;
            num = ((p <<< 31) - b) * 64'sd3125;
            // most negative over minus one wraps back to itself
            if (num == mn && a == -64'sd1) p = mn;
            else p = num / a;
            d = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            b = (p8 * p) >>> 19;
            p = ((p + d + b) >>> 8) + (p7 <<< 4);
            if (p < 0) r.press = '0;
            else if (p > 64'sh0FFFF_FFFF) r.press = 32'hFFFF_FFFF;
            else r.press = p[31:0];
            r.pvalid = 1'b1;
        end
        return r;
    endfunction

    function void note_sample(logic [19:0] raw_t, logic [19:0] raw_p);
        pending.push_back(compensate(raw_t, raw_p));
    endfunction

    function void check_result(logic [31:0] fine, logic [23:0] centi,
                               logic [31:0] press, logic pvalid);
        t_comp e;
        if (pending.size() == 0) begin
            $error("unexpected result item fine_temperature=%h", fine);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (fine !== e.fine) begin
            $error("fine_temperature expected %h actual %h", e.fine, fine);
            errors++;
        end
        if (centi !== e.centi) begin
            $error("temperature_centi expected %h actual %h", e.centi, centi);
            errors++;
        end
        if (press !== e.press) begin
            $error("pressure_q24_8 expected %h actual %h", e.press, press);
            errors++;
        end
        if (pvalid !== e.pvalid) begin
            $error("pressure_valid expected %b actual %b", e.pvalid, pvalid);
            errors++;
        end
    endfunction
endclass

module baro_temp_pressure_compensation_tb
    import bpc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 120;   // idle wait after the last result is checked
    localparam int PHASE_ITEMS = 193;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [BPC_IDX_W-1:0] i_cfg_idx;
    logic [BPC_REG_W-1:0] i_cfg_data;

    bpc_in_if  smp_if ();
    bpc_out_if res_if ();

    baro_temp_pressure_compensation DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp_if),
        .o_res      (res_if)
    );

    bpc_scoreboard sb = new();

    int sent;
    int cycles;
    int send_idle;    // percent of cycles the sender holds off
    int recv_idle;    // percent of cycles the receiver stalls

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Count cycles; abort the run if it hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: stall at random, check every accepted result item.
    always @(negedge i_clk) begin
        res_if.ready = ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.fine_temperature, res_if.temperature_centi,
                            res_if.pressure_q24_8, res_if.pressure_valid);
    end

    // Pick the idle mix from how far the stimulus has gone.
    function void update_idle();
        if (sent < 480) begin
            send_idle = 34; recv_idle = 46;
        end else if (sent < 960) begin
            send_idle = 46; recv_idle = 34;
        end else begin
            send_idle = 0;  recv_idle = 0;
        end
    endfunction

    task automatic send_sample(logic [19:0] raw_t, logic [19:0] raw_p);
        update_idle();
        while ($urandom_range(99) < send_idle) begin
            smp_if.valid = 1'b0;
            @(negedge i_clk);
        end
        smp_if.valid           = 1'b1;
        smp_if.raw_temperature = raw_t;
        smp_if.raw_pressure    = raw_p;
        do @(posedge i_clk); while (!smp_if.ready);
        sb.note_sample(raw_t, raw_p);
        sent++;
        @(negedge i_clk);
        smp_if.valid = 1'b0;
    endtask

    // Drain everything in flight, then wait out the pipeline.
    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [BPC_IDX_W-1:0] idx, logic [BPC_REG_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        sb.write_cal(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function logic [47:0] rnd48();
        return 48'({$urandom(), $urandom()});
    endfunction

    task automatic load_cal(logic [47:0] t, logic [47:0] a, logic [47:0] b, logic [47:0] c);
        write_reg(REG_TEMP, t);
        write_reg(REG_PRESS_A, a);
        write_reg(REG_PRESS_B, b);
        write_reg(REG_PRESS_C, c);
        // out-of-range index: must leave the calibration untouched
        write_reg(BPC_IDX_W'($urandom_range(7, 4)), rnd48());
    endtask

    // Mostly plausible raw readings, some anywhere in the 20-bit range.
    task automatic random_items(int n, bit pause_mid);
        logic [19:0] rt, rp;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) begin
                rt = 20'($urandom());
                rp = 20'($urandom());
            end else begin
                rt = 20'($urandom_range(600000, 400000));
                rp = 20'($urandom_range(500000, 250000));
            end
            send_sample(rt, rp);
            // hold off the sender once until the block has emptied
            if (pause_mid && i == n / 2)
                while (sb.pending.size() != 0) @(negedge i_clk);
        end
    endtask

    initial begin
        logic [47:0] typ_t, typ_a, typ_b, typ_c;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = '0;
        i_cfg_data             = '0;
        smp_if.valid           = 1'b0;
        smp_if.raw_temperature = '0;
        smp_if.raw_pressure    = '0;
        res_if.ready           = 1'b0;
        sent   = 0;
        cycles = 0;
        update_idle();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset calibration: divisor is zero, pressure forced to zero.
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h7EEA0, 20'h6559C);
        drain();

        // Datasheet-style calibration; sweep the raw extremes.
        typ_t = {16'hFC18, 16'h6743, 16'd27504};
        typ_a = {16'd3024, 16'hD643, 16'd36477};
        typ_b = {16'hFFF9, 16'd140, 16'd2855};
        typ_c = {16'd6000, 16'hC6F8, 16'd15500};
        load_cal(typ_t, typ_a, typ_b, typ_c);
        send_sample(20'd519888, 20'd415148);
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h00000, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'h00000);
        send_sample(20'h55555, 20'hAAAAA);
        send_sample(20'hAAAAA, 20'h55555);
        send_sample(20'h80000, 20'h80000);
        send_sample(20'h7FFFF, 20'h7FFFF);
        send_sample(20'h00001, 20'h00001);
        random_items(PHASE_ITEMS, 1'b0);
        drain();

        // Extreme calibration words: all ones, then signed extremes.
        load_cal('1, '1, '1, '1);
        send_sample(20'h00000, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'h00000);
        random_items(PHASE_ITEMS, 1'b1);
        drain();

        load_cal({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'hFFFF},
                 {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF});
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hFFFFF, 20'hFFFFF);
        random_items(PHASE_ITEMS, 1'b0);
        drain();

        // P1 zero forces the zero-divisor path with live temperature.
        load_cal(rnd48(), rnd48() & 48'hFFFF_FFFF_0000, rnd48(), rnd48());
        random_items(60, 1'b0);
        drain();

        // Typical temperature, random pressure words: hits both saturation ends.
        for (int ph = 0; ph < 3; ph++) begin
            load_cal(typ_t, rnd48(), rnd48(), rnd48());
            random_items(PHASE_ITEMS, 1'b0);
            drain();
        end

        load_cal(rnd48(), rnd48(), rnd48(), rnd48());
        random_items(PHASE_ITEMS, 1'b0);
        drain();

        load_cal('0, '0, '0, '0);
        random_items(20, 1'b0);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
